/* rtl/core/lcal_pkg.sv */
// Shared types and constants for the binary-lifting ancestor engine.
`default_nettype none
package lcal_pkg;

  localparam int NODE_W  = 16;
  localparam int DEPTH_W = 16;
  localparam int RECIP_SHIFT = 32;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } lcal_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WMUL,
    ST_WQM,
    ST_WSUB,
    ST_DISP,
    ST_LD_LV,
    ST_Q_DA,
    ST_Q_DB,
    ST_Q_SW,
    ST_Q_UP,
    ST_Q_UPW,
    ST_Q_EQ,
    ST_Q_BB,
    ST_Q_BC,
    ST_Q_FIN,
    ST_Q_OUT
  } lcal_state_t;

endpackage
`default_nettype wire

/* rtl/core/lowest_common_ancestor_lifting.sv */
// Binary-lifting lowest common ancestor engine: node loads and ancestor queries.
//
//  channel | dir | handshake          | beat fields
//  --------+-----+--------------------+-------------------------------
//  in      | in  | in_valid/in_stall  | mode, first_node, second_node
//  out     | out | out_valid/out_stall| ancestor (queries only)
//
// Load beat: accept, wrap both nodes, dispatch, then fill the jump-table row level by level.
// Query beat: read both depths, lift the deeper node, and finish when the lifted node meets the other, else
// climb both nodes level by level; one jump-table read per lift step, two per level when both climb.
// Node wrap uses one shared 16x32 multiplier. Reset clears control only; node 0 reads as zero.
// A finished result waits in the output register while the next beat is taken; a second
// result holds the engine in its last state until the slot frees.
`default_nettype none
module lowest_common_ancestor_lifting
  import lcal_pkg::*;
#(
  parameter int MAX_NODES   = 65536,
  parameter int LIFT_LEVELS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              mode,
  input  wire logic [NODE_W-1:0] first_node,
  input  wire logic [NODE_W-1:0] second_node,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [NODE_W-1:0] ancestor
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int LW = $clog2(LIFT_LEVELS);
  localparam int AW = NW + LW;
  localparam int JDEPTH = MAX_NODES << LW;
  localparam int MUL_W = NODE_W + RECIP_SHIFT;
  localparam logic [RECIP_SHIFT-1:0] RECIP =
    RECIP_SHIFT'(((64'd1 << RECIP_SHIFT) + 64'(MAX_NODES) - 64'd1) / 64'(MAX_NODES));
  localparam logic [LW-1:0] LAST_LV = LW'(LIFT_LEVELS - 1);

  // memories
  logic [NODE_W-1:0]  jump_mem [0:JDEPTH-1];
  logic [DEPTH_W-1:0] dep_mem  [0:MAX_NODES-1];

  lcal_state_t state, state_next;

  logic              mode_q;
  logic              wsel;
  logic [NODE_W-1:0] a, b, pa;
  logic [DEPTH_W-1:0] da, gap;
  logic [LW-1:0]     lv;
  logic [MUL_W-1:0]  prod;

  logic [NODE_W-1:0]      mul_x;
  logic [RECIP_SHIFT-1:0] mul_y;
  logic [MUL_W-1:0]       mul_out;
  logic [NODE_W-1:0]      opnd, rem;

  logic              jrd_en, jwr_en;
  logic [NODE_W-1:0] jrd_node, jwr_node, jwr_data;
  logic [LW-1:0]     jrd_lv, jwr_lv;
  logic [AW-1:0]     jrd_addr, jwr_addr;
  logic [NODE_W-1:0] jrd_q, jval;
  logic              jrd_zero;

  logic               drd_en, dwr_en;
  logic [NODE_W-1:0]  drd_node;
  logic [DEPTH_W-1:0] drd_q, dval;
  logic               drd_zero;

  logic              in_acc, out_free;
  logic              up_take;
  logic              differ;
  logic [NODE_W-1:0] na, nb;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // shared multiplier: reciprocal step, then quotient times modulus
  assign opnd    = wsel ? b : a;
  assign mul_out = MUL_W'(mul_x) * MUL_W'(mul_y);
  // quotient is exact for 16-bit operands, so the remainder needs no fixup
  assign rem     = opnd - prod[NODE_W-1:0];

  always_comb begin
    if (state == ST_WQM) begin
      mul_x = prod[MUL_W-1:RECIP_SHIFT];
      mul_y = RECIP_SHIFT'(MAX_NODES);
    end else begin
      mul_x = opnd;
      mul_y = RECIP;
    end
  end

  assign jval = jrd_zero ? '0 : jrd_q;
  assign dval = drd_zero ? '0 : drd_q;

  assign up_take = ((gap >> lv) != '0);
  assign differ  = (pa != jval);
  assign na      = differ ? pa : a;
  assign nb      = differ ? jval : b;

  assign jrd_addr = {NW'(jrd_node), jrd_lv};
  assign jwr_addr = {NW'(jwr_node), jwr_lv};

  // sequencer
  always_comb begin
    state_next = state;
    jrd_en   = 1'b0;
    jrd_node = a;
    jrd_lv   = lv;
    jwr_en   = 1'b0;
    jwr_node = a;
    jwr_lv   = lv;
    jwr_data = jval;
    drd_en   = 1'b0;
    drd_node = a;
    dwr_en   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) state_next = ST_WMUL;
      end
      ST_WMUL: state_next = ST_WQM;
      ST_WQM:  state_next = ST_WSUB;
      ST_WSUB: state_next = wsel ? ST_DISP : ST_WMUL;
      ST_DISP: begin
        if (mode_q == MODE_QUERY) begin
          drd_en     = 1'b1;
          drd_node   = a;
          state_next = ST_Q_DA;
        end else if (a == '0) begin
          state_next = ST_IDLE;
        end else begin
          drd_en     = 1'b1;
          drd_node   = b;
          jwr_en     = 1'b1;
          jwr_lv     = '0;
          jwr_data   = b;
          jrd_en     = 1'b1;
          jrd_node   = b;
          jrd_lv     = '0;
          state_next = ST_LD_LV;
        end
      end
      ST_LD_LV: begin
        jwr_en   = 1'b1;
        jwr_data = jval;
        dwr_en   = (lv == LW'(1));
        if (lv == LAST_LV) begin
          state_next = ST_IDLE;
        end else begin
          jrd_en   = 1'b1;
          jrd_node = jval;
          jrd_lv   = lv;
        end
      end
      ST_Q_DA: begin
        drd_en     = 1'b1;
        drd_node   = b;
        state_next = ST_Q_DB;
      end
      ST_Q_DB: state_next = ST_Q_SW;
      ST_Q_SW: state_next = ST_Q_UP;
      ST_Q_UP: begin
        if (up_take) begin
          jrd_en     = 1'b1;
          state_next = ST_Q_UPW;
        end else if (lv == '0) begin
          state_next = ST_Q_EQ;
        end
      end
      ST_Q_UPW: state_next = (lv == '0) ? ST_Q_EQ : ST_Q_UP;
      ST_Q_EQ: begin
        if (a == b) begin
          state_next = ST_Q_OUT;
        end else begin
          jrd_en     = 1'b1;
          jrd_lv     = LAST_LV;
          state_next = ST_Q_BB;
        end
      end
      ST_Q_BB: begin
        jrd_en     = 1'b1;
        jrd_node   = b;
        state_next = ST_Q_BC;
      end
      ST_Q_BC: begin
        jrd_en   = 1'b1;
        jrd_node = na;
        if (lv == '0) begin
          jrd_lv     = '0;
          state_next = ST_Q_FIN;
        end else begin
          jrd_lv     = lv - LW'(1);
          state_next = ST_Q_BB;
        end
      end
      ST_Q_FIN: state_next = ST_Q_OUT;
      ST_Q_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          mode_q <= mode;
          a      <= first_node;
          b      <= second_node;
          wsel   <= 1'b0;
        end
      end
      ST_WMUL, ST_WQM: prod <= mul_out;
      ST_WSUB: begin
        if (wsel) begin
          b <= rem;
        end else begin
          a    <= rem;
          wsel <= 1'b1;
        end
      end
      ST_DISP: lv <= LW'(1);
      ST_LD_LV: lv <= lv + LW'(1);
      // depth of a arrives here; depth of b lands in the cycle after
      ST_Q_DA: da <= dval;
      ST_Q_DB: ;
      ST_Q_SW: begin
        lv <= LAST_LV;
        if (da < dval) begin
          a   <= b;
          b   <= a;
          gap <= dval - da;
        end else begin
          gap <= da - dval;
        end
      end
      ST_Q_UP: begin
        if (up_take) begin
          gap <= gap - (DEPTH_W'(1) << lv);
        end else if (lv != '0) begin
          lv <= lv - LW'(1);
        end
      end
      ST_Q_UPW: begin
        a <= jval;
        if (lv != '0) lv <= lv - LW'(1);
      end
      ST_Q_EQ: lv <= LAST_LV;
      ST_Q_BB: pa <= jval;
      ST_Q_BC: begin
        a <= na;
        b <= nb;
        if (lv != '0) lv <= lv - LW'(1);
      end
      ST_Q_FIN: a <= jval;
      ST_Q_OUT: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_Q_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_Q_OUT && out_free) ancestor <= a;
  end

  // jump table, write-first on a same-address read
  always_ff @(posedge clk) begin
    if (jwr_en) jump_mem[jwr_addr] <= jwr_data;
    if (jrd_en) begin
      if (jwr_en && jwr_addr == jrd_addr) begin
        jrd_q <= jwr_data;
      end else begin
        jrd_q <= jump_mem[jrd_addr];
      end
      jrd_zero <= (jrd_node == '0);
    end
  end

  // depth table
  always_ff @(posedge clk) begin
    if (dwr_en) dep_mem[NW'(a)] <= dval + DEPTH_W'(1);
    if (drd_en) begin
      drd_q    <= dep_mem[NW'(drd_node)];
      drd_zero <= (drd_node == '0);
    end
  end

  // node 0 is the sentinel and must never be stored
  a_no_root_write: assert property (@(posedge clk) disable iff (rst)
    jwr_en |-> jwr_node != '0)
    else $error("jump table write to sentinel node");

  a_wrapped: assert property (@(posedge clk) disable iff (rst)
    state == ST_DISP |-> (32'(a) < 32'(MAX_NODES)) && (32'(b) < 32'(MAX_NODES)))
    else $error("node number not reduced below table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> in_stall)
    else $error("engine free right after accepting a beat");

  a_gap_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_Q_UP) && up_take |=> gap < $past(gap))
    else $error("depth gap did not shrink on a lift step");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_Q_OUT)
    else $error("result raised outside the result state");

endmodule
`default_nettype wire
